>>> rtl/core/tga_pixel_stream_decoder_defines.svh
// Assertion macros shared by the pixel stream decoder RTL.
// No dependencies; the checks compile away when SYNTH is defined.
`ifndef TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define TPSD_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TPSD_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPSD_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons, msg)
`define TPSD_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg)
`endif
`endif

>>> rtl/core/tpsd_pkg.sv
// Shared types, codes and helpers for the pixel stream decoder.
// No dependencies; imported by tpsd_front, tpsd_back and the top level.
package tpsd_pkg;

	// Default sizes for the top-level parameters.
	localparam int ColormapDepthDef  = 256;
	localparam int PixelCountBitsDef = 24;

	// Internal queue depths (powers of two).
	localparam int CmdQueueDepth = 4;
	localparam int ResQueueDepth = 2;

	// Configuration port.
	localparam int CfgIndexBits = 3;
	localparam int CfgDataBits  = 24;

	localparam logic [CfgIndexBits-1:0] CFG_PIXEL_FORMAT    = 3'd0;
	localparam logic [CfgIndexBits-1:0] CFG_RLE_ENABLE      = 3'd1;
	localparam logic [CfgIndexBits-1:0] CFG_PIXEL_COUNT     = 3'd2;
	localparam logic [CfgIndexBits-1:0] CFG_ID_SKIP_LENGTH  = 3'd3;
	localparam logic [CfgIndexBits-1:0] CFG_COLORMAP_ENTRIES = 3'd4;

	// Pixel format codes.
	localparam logic [2:0] FMT_INDEXED8   = 3'd0;
	localparam logic [2:0] FMT_RGB16      = 3'd1;
	localparam logic [2:0] FMT_BGR24      = 3'd2;
	localparam logic [2:0] FMT_BGRA32     = 3'd3;
	localparam logic [2:0] FMT_GRAY8      = 3'd4;
	localparam logic [2:0] FMT_GRAY_ALPHA = 3'd5;

	// Packet header and 16-bit color field masks.
	localparam logic [7:0]  RLE_COUNT_MASK = 8'h7F;
	localparam logic [7:0]  RLE_RUN_MASK   = 8'h80;
	localparam logic [15:0] RGB16_RED_MASK = 16'h7C00;
	localparam logic [15:0] RGB16_GRN_MASK = 16'h03E0;
	localparam logic [15:0] RGB16_BLU_MASK = 16'h001F;

	// One entry of the queue between front and back: a colormap write or a pixel.
	typedef struct packed {
		logic        is_write;
		logic [2:0]  fmt;
		logic        in_map;
		logic [7:0]  cm_addr;
		logic [31:0] data;
		logic [7:0]  repeat_count;
		logic        image_end;
		logic        overrun;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] chan_red;
		logic [7:0] chan_green;
		logic [7:0] chan_blue;
		logic [7:0] chan_alpha;
		logic [7:0] repeat_count;
		logic       image_end;
		logic       overrun;
	} result_t;

	// Bytes that make up one pixel; unused codes behave as gray8.
	function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
		logic [2:0] n;
		unique case (fmt)
			FMT_RGB16:      n = 3'd2;
			FMT_BGR24:      n = 3'd3;
			FMT_BGRA32:     n = 3'd4;
			FMT_GRAY_ALPHA: n = 3'd2;
			default:        n = 3'd1;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/core/tpsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tpsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/tpsd_fifo.sv
// Small synchronous FIFO, flags decoded from a fill register.
// No dependencies; DEPTH must be a power of two.
module tpsd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/tpsd_front.sv
// Front end: configuration registers, stream phase tracking and pixel assembly.
// Depends on tpsd_pkg; emits colormap writes and pixel commands to the queue.
module tpsd_front import tpsd_pkg::*; #(
	parameter int COLORMAP_DEPTH   = ColormapDepthDef,
	parameter int PIXEL_COUNT_BITS = PixelCountBitsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0]  cfg_data,
	input  logic                    push,
	input  logic [7:0]              data_byte,
	input  logic                    start_of_stream,
	output logic                    full,
	input  logic                    cmd_full,
	output logic                    cmd_push,
	output cmd_t                    cmd
);

	localparam int PCB = PIXEL_COUNT_BITS;
	localparam logic [8:0] MapDepth = 9'(COLORMAP_DEPTH);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_CMAP,
		PH_HEAD,
		PH_PIX,
		PH_DONE
	} phase_t;

	// Configuration registers.
	logic [2:0]  fmt_q;
	logic        rle_q;
	logic [23:0] count_q;
	logic [7:0]  idskip_q;
	logic [8:0]  entries_q;

	// Stream state.
	phase_t          phase_q, phase_d;
	logic [9:0]      byte_cnt_q, byte_cnt_d;
	logic [23:0]     asm_q, asm_d;
	logic [1:0]      nbytes_q, nbytes_d;
	logic [7:0]      pkt_rem_q, pkt_rem_d;
	logic            pkt_run_q, pkt_run_d;
	logic [PCB-1:0]  left_q, left_d;
	logic [8:0]      cm_idx_q, cm_idx_d;
	logic [8:0]      cm_loaded_q, cm_loaded_d;
	logic            clip_q, clip_d;
	logic            rle_mode_q, rle_mode_d;

	logic        accept;
	logic        cmd_valid;
	logic [7:0]  hdr_count;
	logic [7:0]  pix_count;
	logic [2:0]  bpp;
	logic [31:0] pix_value;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign cmd_push = accept && cmd_valid;
	assign bpp      = bytes_per_pixel(fmt_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_BGR24;
			rle_q     <= 1'b0;
			count_q   <= '0;
			idskip_q  <= '0;
			entries_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PIXEL_FORMAT:     fmt_q     <= cfg_data[2:0];
				CFG_RLE_ENABLE:       rle_q     <= cfg_data[0];
				CFG_PIXEL_COUNT:      count_q   <= cfg_data[23:0];
				CFG_ID_SKIP_LENGTH:   idskip_q  <= cfg_data[7:0];
				CFG_COLORMAP_ENTRIES: entries_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Next-state logic for one accepted byte: restart, phase settling, then the byte itself.
	always_comb begin
		phase_d     = phase_q;
		byte_cnt_d  = byte_cnt_q;
		asm_d       = asm_q;
		nbytes_d    = nbytes_q;
		pkt_rem_d   = pkt_rem_q;
		pkt_run_d   = pkt_run_q;
		left_d      = left_q;
		cm_idx_d    = cm_idx_q;
		cm_loaded_d = cm_loaded_q;
		clip_d      = clip_q;
		rle_mode_d  = rle_mode_q;
		cmd         = '0;
		cmd_valid   = 1'b0;
		hdr_count   = '0;
		pix_count   = '0;
		pix_value   = '0;

		if (start_of_stream) begin
			phase_d     = PH_SKIP;
			byte_cnt_d  = '0;
			asm_d       = '0;
			nbytes_d    = '0;
			pkt_rem_d   = '0;
			pkt_run_d   = 1'b0;
			cm_idx_d    = '0;
			cm_loaded_d = '0;
			clip_d      = 1'b0;
			left_d      = PCB'(count_q);
		end

		// Pass over phases that are already complete.
		if (phase_d == PH_SKIP && byte_cnt_d >= {2'b00, idskip_q}) begin
			phase_d  = PH_CMAP;
			cm_idx_d = '0;
			nbytes_d = '0;
			asm_d    = '0;
		end
		if (phase_d == PH_CMAP && cm_idx_d >= entries_q) begin
			rle_mode_d = rle_q;
			nbytes_d   = '0;
			asm_d      = '0;
			phase_d    = rle_q ? PH_HEAD : PH_PIX;
		end
		if ((phase_d == PH_HEAD || phase_d == PH_PIX) && left_d == '0) begin
			phase_d = PH_DONE;
		end

		unique case (phase_d)
			PH_SKIP: begin
				byte_cnt_d = byte_cnt_d + 10'd1;
			end
			PH_CMAP: begin
				if (nbytes_d < 2'd2) begin
					asm_d    = asm_d | (24'(data_byte) << {nbytes_d, 3'b000});
					nbytes_d = nbytes_d + 2'd1;
				end else begin
					// Third byte completes a B, G, R entry.
					if (cm_idx_d < MapDepth) begin
						cmd.is_write = 1'b1;
						cmd.cm_addr  = cm_idx_d[7:0];
						cmd.data     = {8'h00, data_byte, asm_d[15:0]};
						cmd_valid    = 1'b1;
						cm_loaded_d  = cm_idx_d + 9'd1;
					end
					cm_idx_d = cm_idx_d + 9'd1;
					nbytes_d = '0;
					asm_d    = '0;
				end
			end
			PH_HEAD: begin
				// Packet header: count in the low bits, run flag on top.
				hdr_count = (data_byte & RLE_COUNT_MASK) + 8'd1;
				pkt_run_d = (data_byte & RLE_RUN_MASK) != 8'h00;
				if (PCB'(hdr_count) > left_d) begin
					clip_d    = 1'b1;
					hdr_count = left_d[7:0];
				end else begin
					clip_d = 1'b0;
				end
				pkt_rem_d = hdr_count;
				nbytes_d  = '0;
				asm_d     = '0;
				phase_d   = PH_PIX;
			end
			PH_PIX: begin
				if ({1'b0, nbytes_d} + 3'd1 < bpp) begin
					asm_d    = asm_d | (24'(data_byte) << {nbytes_d, 3'b000});
					nbytes_d = nbytes_d + 2'd1;
				end else begin
					// Pixel complete: work out its repeat and update the counters.
					pix_value = {8'h00, asm_d} | (32'(data_byte) << {nbytes_d, 3'b000});
					nbytes_d  = '0;
					asm_d     = '0;
					pix_count = (rle_mode_d && pkt_run_d) ? pkt_rem_d : 8'd1;
					if (pix_count == 8'd0) begin
						pix_count = 8'd1;
					end
					if (PCB'(pix_count) > left_d) begin
						pix_count = left_d[7:0];
					end
					left_d = left_d - PCB'(pix_count);
					if (rle_mode_d) begin
						pkt_rem_d = (pkt_rem_d >= pix_count) ? pkt_rem_d - pix_count : 8'd0;
					end
					cmd.is_write     = 1'b0;
					cmd.fmt          = fmt_q;
					cmd.in_map       = {1'b0, pix_value[7:0]} < cm_loaded_d;
					cmd.data         = pix_value;
					cmd.repeat_count = pix_count;
					cmd.image_end    = (left_d == '0);
					cmd.overrun      = rle_mode_d && clip_d;
					cmd_valid        = 1'b1;
					if (left_d == '0) begin
						phase_d = PH_DONE;
					end else if (rle_mode_d && pkt_rem_d == 8'd0) begin
						phase_d = PH_HEAD;
					end
				end
			end
			PH_DONE: ;
			default: ;
		endcase
	end

	// State registers update on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			byte_cnt_q  <= '0;
			asm_q       <= '0;
			nbytes_q    <= '0;
			pkt_rem_q   <= '0;
			pkt_run_q   <= 1'b0;
			left_q      <= '0;
			cm_idx_q    <= '0;
			cm_loaded_q <= '0;
			clip_q      <= 1'b0;
			rle_mode_q  <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			byte_cnt_q  <= byte_cnt_d;
			asm_q       <= asm_d;
			nbytes_q    <= nbytes_d;
			pkt_rem_q   <= pkt_rem_d;
			pkt_run_q   <= pkt_run_d;
			left_q      <= left_d;
			cm_idx_q    <= cm_idx_d;
			cm_loaded_q <= cm_loaded_d;
			clip_q      <= clip_d;
			rle_mode_q  <= rle_mode_d;
		end
	end

endmodule

>>> rtl/core/tpsd_back.sv
// Back end: executes queued colormap writes and pixel lookups, formats results.
// Depends on tpsd_pkg and tpsd_ram.
module tpsd_back import tpsd_pkg::*; #(
	parameter int COLORMAP_DEPTH = ColormapDepthDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	localparam int AW = $clog2(COLORMAP_DEPTH);

	logic        valid_s1;
	cmd_t        entry_s1;
	logic [23:0] map_rdata;
	logic        map_we;
	logic        map_re;

	// Take the next command when stage one is free or drains this cycle.
	assign cmd_pop  = !cmd_empty && (!valid_s1 || !res_full);
	assign res_push = valid_s1 && !res_full;
	assign map_we   = cmd_pop && cmd.is_write;
	assign map_re   = cmd_pop && !cmd.is_write;

	tpsd_ram #(
		.WIDTH (24),
		.DEPTH (COLORMAP_DEPTH)
	) u_colormap (
		.clk   (clk),
		.we    (map_we),
		.waddr (cmd.cm_addr[AW-1:0]),
		.wdata (cmd.data[23:0]),
		.re    (map_re),
		.raddr (cmd.data[AW-1:0]),
		.rdata (map_rdata)
	);

	// Stage one holds a pixel while its colormap read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_pop) begin
			valid_s1 <= !cmd.is_write;
		end else if (res_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			entry_s1 <= cmd;
		end
	end

	// Channel expansion per pixel format.
	always_comb begin
		res              = '0;
		res.repeat_count = entry_s1.repeat_count;
		res.image_end    = entry_s1.image_end;
		res.overrun      = entry_s1.overrun;
		unique case (entry_s1.fmt)
			FMT_INDEXED8: begin
				if (entry_s1.in_map) begin
					res.chan_red   = map_rdata[23:16];
					res.chan_green = map_rdata[15:8];
					res.chan_blue  = map_rdata[7:0];
				end
			end
			FMT_RGB16: begin
				res.chan_red   = {5'((entry_s1.data[15:0] & RGB16_RED_MASK) >> 10), 3'b000};
				res.chan_green = {5'((entry_s1.data[15:0] & RGB16_GRN_MASK) >> 5), 3'b000};
				res.chan_blue  = {5'(entry_s1.data[15:0] & RGB16_BLU_MASK), 3'b000};
			end
			FMT_BGR24: begin
				res.chan_red   = entry_s1.data[23:16];
				res.chan_green = entry_s1.data[15:8];
				res.chan_blue  = entry_s1.data[7:0];
			end
			FMT_BGRA32: begin
				res.chan_red   = entry_s1.data[23:16];
				res.chan_green = entry_s1.data[15:8];
				res.chan_blue  = entry_s1.data[7:0];
				res.chan_alpha = entry_s1.data[31:24];
			end
			FMT_GRAY_ALPHA: begin
				res.chan_red   = entry_s1.data[7:0];
				res.chan_green = entry_s1.data[15:8];
			end
			default: begin
				res.chan_red = entry_s1.data[7:0];
			end
		endcase
	end

endmodule

>>> rtl/core/tga_pixel_stream_decoder.sv
// Top level of the TGA pixel stream decoder: front end, command queue, back end,
// result queue. Depends on tpsd_pkg, tpsd_fifo, tpsd_front, tpsd_back.
//
// Usage:
//   Input channel: one file body byte per beat (data_byte, start_of_stream),
//   taken at a clock edge with push high and full low. start_of_stream marks
//   the first byte after the header and restarts all counters.
//   Result channel: while empty is low the oldest result (RGBA, repeat_count,
//   image_end, overrun) is on the ports; pop high takes it.
//   Configuration: cfg_wr_en, cfg_index, cfg_data write a register;
//   write only while the block is idle.
//   Throughput: one byte per cycle while full is low. The front end handles each
//   byte as it is taken; the back end runs one command (colormap write or pixel
//   lookup) per cycle while the result queue is not full. A result passes the
//   command queue, the colormap read stage and the result queue to the ports.
//   Stalls: when pop stays low the result queue fills, the back end halts and
//   the command queue absorbs up to four more commands before full rises.
//   Reset: arst_n clears all control state; registers return to bgr24 format,
//   RLE off, all counts zero. The colormap RAM is not cleared and needs no
//   clearing pass; an index beyond the entries loaded reads as black.
`include "tga_pixel_stream_decoder_defines.svh"
module tga_pixel_stream_decoder import tpsd_pkg::*; #(
	parameter int COLORMAP_DEPTH   = ColormapDepthDef,
	parameter int PIXEL_COUNT_BITS = PixelCountBitsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0]  cfg_data,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              data_byte,
	input  logic                    start_of_stream,
	output logic                    empty,
	input  logic                    pop,
	output logic [7:0]              chan_red,
	output logic [7:0]              chan_green,
	output logic [7:0]              chan_blue,
	output logic [7:0]              chan_alpha,
	output logic [7:0]              repeat_count,
	output logic                    image_end,
	output logic                    overrun
);

	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	result_t res_in;
	result_t res_out;
	logic    res_push;
	logic    res_full;

	// Byte intake and classification.
	tpsd_front #(
		.COLORMAP_DEPTH   (COLORMAP_DEPTH),
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.data_byte       (data_byte),
		.start_of_stream (start_of_stream),
		.full            (full),
		.cmd_full        (cmd_full),
		.cmd_push        (cmd_push),
		.cmd             (cmd_in)
	);

	// Decoupling queue between front and back.
	tpsd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CmdQueueDepth)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// Colormap access and channel formatting.
	tpsd_back #(
		.COLORMAP_DEPTH (COLORMAP_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Output queue decouples the receiver from the back end.
	tpsd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (ResQueueDepth)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign chan_red     = res_out.chan_red;
	assign chan_green   = res_out.chan_green;
	assign chan_blue    = res_out.chan_blue;
	assign chan_alpha   = res_out.chan_alpha;
	assign repeat_count = res_out.repeat_count;
	assign image_end    = res_out.image_end;
	assign overrun      = res_out.overrun;

	// Internal consistency checks.
	`TPSD_ASSERT_NOW(a_cmd_no_overflow, clk, arst_n, cmd_push, !cmd_full, "command queue written while full")
	`TPSD_ASSERT_NOW(a_res_no_overflow, clk, arst_n, res_push, !res_full, "result queue written while full")
	`TPSD_ASSERT_NOW(a_repeat_range, clk, arst_n, !empty, repeat_count != 8'd0 && repeat_count <= 8'd128, "repeat count out of range")
	`TPSD_ASSERT_NEXT(a_res_visible, clk, arst_n, res_push && empty, !empty, "pushed result not visible")

endmodule
